FILE: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue
// Opcodes, status codes and the packed words that the two channels carry.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Opcodes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_word_t;

endpackage

FILE: hw/rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Ring buffer of DEPTH entries in a synchronous RAM, with push/pop at either
// end and a front-to-back dump.
// ----------------------------------------------------------------------------
// Each input word carries an opcode: push front, push back, pop front, pop
// back or dump. Pushes, pops on an empty queue, pushes on a full queue and
// unused opcodes are settled from the idle state; unused opcodes give no
// result. A pop that returns a word passes through S_READ, since the entry
// comes from the RAM's registered read port. A dump of N stored words makes
// N RAM reads, one read per cycle while the output register is free, and
// emits the words front to back with last set on the final one; a dump of an
// empty queue gives one empty result. Results sit in one output register, so
// the next input word is taken while a result still waits, as long as the
// consumer frees that register in the same cycle. A word written by a push
// is visible to any later read, so no forwarding path is needed.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_word_t out_word
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic            out_free;
  logic            is_full;
  logic            is_empty;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [31:0]     wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     rd_data;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign in_ready = (state_r == S_IDLE) && out_free;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    wr_data       = in_word.value;
    rd_en         = 1'b0;
    rd_addr       = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          // immediate result, overwritten below where none is due
          out_valid_nxt       = 1'b1;
          out_word_nxt.data   = '0;
          out_word_nxt.status = STAT_OK;
          out_word_nxt.last   = 1'b1;
          unique case (in_word.opcode)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_word_nxt.status = STAT_FULL;
              end else begin
                front_nxt = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_word_nxt.status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring_add(front_r, count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_word_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = front_r;
                front_nxt     = ring_add(front_r, CW'(1));
                count_nxt     = count_r - 1'b1;
                left_nxt      = '0;
                state_nxt     = S_READ;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_word_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = ring_add(front_r, count_r - 1'b1);
                count_nxt     = count_r - 1'b1;
                left_nxt      = '0;
                state_nxt     = S_READ;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                out_word_nxt.status = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_en         = 1'b1;
                rd_addr       = front_r;
                rd_ptr_nxt    = front_r;
                left_nxt      = count_r - 1'b1;
                state_nxt     = S_READ;
              end
            end
            default: begin
              // unused opcode: swallowed, no result
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end

      // deliver the word held at the RAM read port; a dump issues the next read
      S_READ: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_word_nxt.data   = rd_data;
          out_word_nxt.status = STAT_OK;
          out_word_nxt.last   = (left_r == '0);
          if (left_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rd_ptr_nxt = ring_add(rd_ptr_r, CW'(1));
            rd_en      = 1'b1;
            rd_addr    = rd_ptr_nxt;
            left_nxt   = left_r - 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and dump walk registers
  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    left_r     <= left_nxt;
    out_word_r <= out_word_nxt;
  end

  // entry store
  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: hw/rtl/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the double-ended queue
// Watches the result channel and flags protocol and encoding slips.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input deq_pkg::out_word_t out_word
);

  import deq_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result dropped or changed while stalled");

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != STAT_BAD)
    else $error("illegal status code");

  // an empty or full result is always the only one of its item, with no data
  a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != STAT_OK |-> out_word.last && out_word.data == '0)
    else $error("error result not final or carries data");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue
// Drives push, pop and dump commands over a valid/ready channel. A deque
// mirror predicts every result word, and each result taken from the block is
// compared field by field with the oldest prediction. Both sides idle in
// random bursts, and one long receiver hold backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int DEPTH = 32;
  // Cycles with no word moving on either channel before the run is abandoned
  localparam int STALL_LIMIT = 1000;
  // Receiver hold used to fill the block and stall its input
  localparam int LONG_HOLD = 80;

  // Opcodes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  // Deque mirror: keeps its own ring and the queue of predicted result words
  class deque_scoreboard #(int SLOTS = 32);
    logic signed [31:0] ring [SLOTS];
    int head;
    int count;
    int mismatches;
    out_word_t pending [$];

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
    endfunction

    function void add_result(logic signed [31:0] data, logic [1:0] status, logic last);
      out_word_t r;
      r.data = data;
      r.status = status;
      r.last = last;
      pending.push_back(r);
    endfunction

    // Apply one accepted command to the mirror and queue what it should emit
    function void absorb_command(in_word_t w);
      int slot;
      case (w.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (count >= SLOTS) begin
            add_result('0, STAT_FULL, 1'b1);
          end else begin
            if (w.opcode == OP_PUSH_FRONT) begin
              head = (head + SLOTS - 1) % SLOTS;
              ring[head] = w.value;
            end else begin
              ring[(head + count) % SLOTS] = w.value;
            end
            count++;
            add_result('0, STAT_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (count == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            if (w.opcode == OP_POP_FRONT) begin
              slot = head;
              head = (head + 1) % SLOTS;
            end else begin
              slot = (head + count - 1) % SLOTS;
            end
            count--;
            add_result(ring[slot], STAT_OK, 1'b1);
          end
        end
        OP_DUMP: begin
          if (count == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < count; i++)
              add_result(ring[(head + i) % SLOTS], STAT_OK, i == count - 1);
          end
        end
        default: ;  // spare opcodes leave no trace
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word data=%0d status=%0d last=%0d",
                         got.data, got.status, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data)
        report($sformatf("data %0d, expected %0d", got.data, want.data));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  deque_scoreboard #(DEPTH) sb;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin : receiver
    int hold_left;
    int burst_left;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.compare_result(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  // Mostly random words, with the extremes and all-ones/zero mixed in
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Offer one command word and hold it until accepted
  task automatic send_word(input logic [2:0] op, input logic signed [31:0] val);
    in_word_t w;
    w.opcode = op;
    w.value = val;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.absorb_command(w);
  endtask

  task automatic send_random_push();
    send_word($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
  endtask

  task automatic send_random_pop();
    send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, rand_word());
  endtask

  initial begin
    int pick;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, spare opcodes, extremes, both ends
    send_word(OP_DUMP, 32'h1234_5678);
    send_word(OP_POP_FRONT, 32'h0);
    send_word(OP_POP_BACK, 32'hFFFF_FFFF);
    send_word(OP_SPARE_A, 32'h7FFF_FFFF);
    send_word(OP_SPARE_B, 32'h8000_0000);
    send_word(OP_SPARE_C, 32'hFFFF_FFFF);
    send_word(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(OP_PUSH_BACK, 32'h8000_0000);
    send_word(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(OP_PUSH_BACK, 32'h0000_0000);
    send_word(OP_DUMP, 32'h0);
    send_word(OP_POP_BACK, 32'h0);
    send_word(OP_POP_FRONT, 32'h0);
    send_word(OP_DUMP, 32'h0);
    send_word(OP_POP_FRONT, 32'h0);
    send_word(OP_POP_BACK, 32'h0);
    send_word(OP_POP_FRONT, 32'h0);
    send_word(OP_DUMP, 32'h0);
    send_word(OP_PUSH_BACK, 32'h5555_5555);
    send_word(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(OP_POP_BACK, 32'h0);
    send_word(OP_POP_BACK, 32'h0);

    // Fill to capacity behind a long receiver hold, then push into a full queue
    hold_request = 1'b1;
    while (sb.count < DEPTH) begin
      if ($urandom_range(0, 9) == 0)
        send_random_pop();
      else
        send_random_push();
    end
    repeat (3) send_random_push();
    send_word(OP_DUMP, rand_word());

    // Drain from random ends, dumping along the way, then pop past empty
    while (sb.count > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_word(OP_DUMP, rand_word());
      else
        send_random_pop();
    end
    repeat (2) send_random_pop();

    // Mixed traffic; the tail runs without idling
    for (int k = 0; k < 12; k++) begin
      if (k == 6)
        quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_random_push();
      else if (pick < 75)
        send_random_pop();
      else if (pick < 90)
        send_word(OP_DUMP, rand_word());
      else
        send_word(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), rand_word());
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue.sv
hw/rtl/deq_checker.sv
dv/testbench.sv
